// ===== src/sxd_pkg.sv =====
`default_nettype none

package sxd_pkg;

	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;

	localparam int COL_W = $clog2(SCREEN_WIDTH);
	localparam int ROW_W = $clog2(SCREEN_HEIGHT);

	// Pixels touched by one sprite row.
	localparam int SPRITE_W = 8;

	// Fixed-point reciprocals for the coordinate wrap; one correction step follows.
	localparam int RECIP_SHIFT = 16;
	localparam int ROW_RECIP   = (1 << RECIP_SHIFT) / SCREEN_HEIGHT;
	localparam int COL_RECIP   = (1 << RECIP_SHIFT) / SCREEN_WIDTH;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_DRAW  = 2'd1,
		FUNC_READ  = 2'd2
	} func_t;

	localparam logic KIND_COLLISION = 1'b0;
	localparam logic KIND_PIXELS    = 1'b1;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [3:0] row_offset;
		logic [7:0] row_bits;
		logic       last_row;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic       collision;
		logic [7:0] pixels;
	} out_item_t;

	// (pos_y + row_offset) mod SCREEN_HEIGHT; the sum stays below 271.
	function automatic logic [ROW_W-1:0] wrap_row(input logic [8:0] v);
		logic [24:0] prod;
		logic [8:0]  quo;
		logic [8:0]  rem;
		prod = 25'(v) * 25'(ROW_RECIP);
		quo  = prod[RECIP_SHIFT +: 9];
		rem  = v - 9'(quo * SCREEN_HEIGHT);
		if (rem >= 9'(SCREEN_HEIGHT)) begin
			rem = rem - 9'(SCREEN_HEIGHT);
		end
		return rem[ROW_W-1:0];
	endfunction

	// pos_x mod SCREEN_WIDTH.
	function automatic logic [COL_W-1:0] wrap_col(input logic [7:0] v);
		logic [24:0] prod;
		logic [8:0]  quo;
		logic [8:0]  rem;
		prod = 25'(v) * 25'(COL_RECIP);
		quo  = prod[RECIP_SHIFT +: 9];
		rem  = 9'(v) - 9'(quo * SCREEN_WIDTH);
		if (rem >= 9'(SCREEN_WIDTH)) begin
			rem = rem - 9'(SCREEN_WIDTH);
		end
		return rem[COL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/sprite_xor_draw_framebuffer.sv =====
// Draw and read items hold stage s1: the framebuffer row is read in the transfer cycle
// and written back (or returned) when s1 completes; one item is in flight.
// A clear item zeroes the screen at once through per-row valid bits.
// Results pass from s1 into an output register and wait there; while it is full, s1 holds.
// Reset (arst_n low) empties the pipeline, clears all row valid bits and the collision flag.
`default_nettype none

module sprite_xor_draw_framebuffer
	import sxd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	logic [SCREEN_WIDTH-1:0] frame_mem [SCREEN_HEIGHT];
	logic [SCREEN_HEIGHT-1:0] row_valid_q;

	logic                    busy_s1;
	func_t                   func_s1;
	logic [ROW_W-1:0]        row_s1;
	logic [COL_W-1:0]        x0_s1;
	logic [SPRITE_W-1:0]     bits_s1;
	logic                    last_s1;
	logic                    valid_s1;
	logic [SCREEN_WIDTH-1:0] rd_word_s1;

	logic                    collision_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic                    in_fire;
	func_t                   in_func;
	logic [ROW_W-1:0]        in_row;
	logic                    has_result;
	logic                    s1_done;
	logic                    mem_we;
	logic [SCREEN_WIDTH-1:0] cur_word;
	logic [SCREEN_WIDTH-1:0] sprite_mask;
	logic [SCREEN_WIDTH-1:0] new_word;
	logic [COL_W:0]          col_sum [SPRITE_W];
	logic [COL_W-1:0]        col_idx [SPRITE_W];
	logic [SPRITE_W-1:0]     read_pixels;
	logic                    hit;

	assign in_ready = !busy_s1;
	assign in_fire  = in_valid && in_ready;
	assign in_func  = func_t'(in_data.func);
	assign in_row   = wrap_row(9'(in_data.pos_y) + 9'(in_data.row_offset));

	assign has_result = busy_s1 &&
		((func_s1 == FUNC_DRAW && last_s1) || func_s1 == FUNC_READ);
	// A result in s1 waits while the output register is still full.
	assign s1_done = busy_s1 && !(has_result && out_valid_q && !out_ready);
	assign mem_we  = s1_done && func_s1 == FUNC_DRAW;

	assign cur_word = valid_s1 ? rd_word_s1 : '0;

	always_comb begin
		sprite_mask = '0;
		read_pixels = '0;
		for (int i = 0; i < SPRITE_W; i++) begin
			col_sum[i] = {1'b0, x0_s1} + (COL_W+1)'(i);
			if (col_sum[i] >= (COL_W+1)'(SCREEN_WIDTH)) begin
				col_sum[i] = col_sum[i] - (COL_W+1)'(SCREEN_WIDTH);
			end
			col_idx[i] = col_sum[i][COL_W-1:0];
			sprite_mask[col_idx[i]] = bits_s1[SPRITE_W-1-i];
			read_pixels[SPRITE_W-1-i] = cur_word[col_idx[i]];
		end
	end

	assign new_word = cur_word ^ sprite_mask;
	assign hit      = collision_q || (|(cur_word & sprite_mask));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[row_s1] <= new_word;
		end
		if (in_fire) begin
			rd_word_s1 <= frame_mem[in_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (in_fire && (in_func == FUNC_DRAW || in_func == FUNC_READ)) begin
			busy_s1 <= 1'b1;
		end else if (s1_done) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1  <= in_func;
			row_s1   <= in_row;
			x0_s1    <= wrap_col(in_data.pos_x);
			bits_s1  <= in_data.row_bits;
			last_s1  <= in_data.last_row;
			valid_s1 <= row_valid_q[in_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (in_fire && in_func == FUNC_CLEAR) begin
			row_valid_q <= '0;
		end else if (mem_we) begin
			row_valid_q[row_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collision_q <= 1'b0;
		end else if (mem_we) begin
			collision_q <= last_s1 ? 1'b0 : hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done && has_result) begin
			if (func_s1 == FUNC_READ) begin
				out_q.kind      <= KIND_PIXELS;
				out_q.collision <= 1'b0;
				out_q.pixels    <= read_pixels;
			end else begin
				out_q.kind      <= KIND_COLLISION;
				out_q.collision <= hit;
				out_q.pixels    <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_func == FUNC_CLEAR) |=> row_valid_q == '0)
		else $error("clear did not invalidate every row");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> row_valid_q[$past(row_s1)])
		else $error("written row not marked valid");

	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && last_s1) |=> !collision_q)
		else $error("collision flag not cleared after last row");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_PIXELS) |-> !out_data.collision)
		else $error("pixel read result carries a collision");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && has_result) |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending output");
`endif

endmodule

`default_nettype wire

// ===== tb/sxd_checker.sv =====
`timescale 1ns / 1ps

module sxd_checker
	import sxd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        errors,
	output int        awaited,
	output int        flagged
);

	logic [SCREEN_WIDTH-1:0] shadow_screen [SCREEN_HEIGHT];
	logic                    shadow_hit;
	out_item_t               awaited_reports[$];
	out_item_t               want;

	task automatic report_mismatch(input string what, input logic [9:0] got,
			input logic [9:0] wanted);
		errors++;
		// Keep the log bounded if the design is badly broken.
		if (errors <= 40) begin
			$display("%0t ns: %s: got %h, expected %h", $time, what, got, wanted);
		end
	endtask

	// Applies one accepted item to the shadow screen and queues the result it causes.
	task automatic shadow_apply(input in_item_t it);
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [8:0]       ysum;
		out_item_t        res;
		ysum = {1'b0, it.pos_y} + 9'(it.row_offset);
		row = ROW_W'(ysum % SCREEN_HEIGHT);
		res = '0;
		case (it.func)
			FUNC_CLEAR: begin
				for (int r = 0; r < SCREEN_HEIGHT; r++) begin
					shadow_screen[r] = '0;
				end
			end
			FUNC_DRAW: begin
				for (int i = 0; i < SPRITE_W; i++) begin
					col = COL_W'((int'(it.pos_x) + i) % SCREEN_WIDTH);
					// Only a lit sprite bit over a lit pixel counts as a collision.
					if (it.row_bits[SPRITE_W-1-i] && shadow_screen[row][col]) begin
						shadow_hit = 1'b1;
					end
					shadow_screen[row][col] = shadow_screen[row][col] ^ it.row_bits[SPRITE_W-1-i];
				end
				if (it.last_row) begin
					res.kind = KIND_COLLISION;
					res.collision = shadow_hit;
					awaited_reports.push_back(res);
					shadow_hit = 1'b0;
				end
			end
			FUNC_READ: begin
				for (int i = 0; i < SPRITE_W; i++) begin
					col = COL_W'((int'(it.pos_x) + i) % SCREEN_WIDTH);
					res.pixels[SPRITE_W-1-i] = shadow_screen[row][col];
				end
				res.kind = KIND_PIXELS;
				awaited_reports.push_back(res);
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < SCREEN_HEIGHT; r++) begin
				shadow_screen[r] = '0;
			end
			shadow_hit = 1'b0;
			awaited_reports.delete();
			errors = 0;
			flagged = 0;
		end else begin
			// The result leaving now always belongs to an earlier transfer, so it is
			// checked before the incoming item is predicted.
			if (out_valid && out_ready) begin
				if (awaited_reports.size() == 0) begin
					report_mismatch("result with nothing awaited", out_data, '0);
				end else begin
					want = awaited_reports.pop_front();
					if (want.collision) begin
						flagged++;
					end
					if (out_data.kind !== want.kind) begin
						report_mismatch("kind", out_data, want);
					end
					if (out_data.collision !== want.collision) begin
						report_mismatch("collision", out_data, want);
					end
					if (out_data.pixels !== want.pixels) begin
						report_mismatch("pixels", out_data, want);
					end
				end
			end
			if (in_valid && in_ready) begin
				shadow_apply(in_data);
			end
		end
		awaited = awaited_reports.size();
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import sxd_pkg::*;

	// The one function code the block must ignore.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int errors;
	int awaited;
	int flagged;
	int tx_idle = 9;
	int rx_idle = 62;
	int n_items = 0;
	int n_draws = 0;
	int n_reads = 0;
	int n_clears = 0;
	int n_ignored = 0;

	sprite_xor_draw_framebuffer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	sxd_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (errors),
		.awaited   (awaited),
		.flagged   (flagged)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle);
	end

	function automatic in_item_t mk(input logic [1:0] f, input logic [7:0] x,
			input logic [7:0] y, input logic [3:0] off, input logic [7:0] bits,
			input logic last);
		in_item_t it;
		it.func = f;
		it.pos_x = x;
		it.pos_y = y;
		it.row_offset = off;
		it.row_bits = bits;
		it.last_row = last;
		return it;
	endfunction

	// Half the coordinates land in one small corner, seen through most of its
	// wrapped aliases, so that sprites often overlap and collide.
	function automatic logic [7:0] coord(input int wrap);
		if ($urandom_range(1)) begin
			return 8'($urandom_range(255));
		end
		return 8'($urandom_range(11) + wrap * $urandom_range(255 / wrap - 1));
	endfunction

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		case (it.func)
			FUNC_DRAW:  n_draws++;
			FUNC_READ:  n_reads++;
			FUNC_CLEAR: n_clears++;
			default:    n_ignored++;
		endcase
		if (it.func != FUNC_UNUSED) begin
			n_items++;
		end
	endtask

	// Holds the sender off until every awaited result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (awaited != 0);
		@(posedge clk);
	endtask

	initial begin
		logic [7:0] x;
		logic [7:0] y;
		int pick;
		int rows;
		int target;
		bit cut;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Screen is blank after reset.
		send_item(mk(FUNC_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0));
		send_item(mk(FUNC_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b1));
		// Same sprite again erases it and reports a collision.
		send_item(mk(FUNC_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b1));
		send_item(mk(FUNC_READ, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b1));
		// Largest coordinates: the row wraps vertically and straddles the right edge.
		send_item(mk(FUNC_DRAW, 8'hFF, 8'hFF, 4'hF, 8'hA5, 1'b0));
		send_item(mk(FUNC_READ, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1));
		send_item(mk(FUNC_READ, 8'd60, 8'd14, 4'd0, 8'h00, 1'b0));
		// Zero sprite bits over lit pixels must not count as a collision.
		send_item(mk(FUNC_DRAW, 8'd63, 8'd14, 4'd0, 8'h00, 1'b1));
		// A hit on an early row stays set through later rows and a clear.
		send_item(mk(FUNC_DRAW, 8'd60, 8'd14, 4'd0, 8'hF0, 1'b0));
		send_item(mk(FUNC_DRAW, 8'd10, 8'd2, 4'd1, 8'h81, 1'b0));
		send_item(mk(FUNC_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1));
		send_item(mk(FUNC_READ, 8'd60, 8'd14, 4'd0, 8'h00, 1'b0));
		send_item(mk(FUNC_DRAW, 8'd10, 8'd3, 4'd0, 8'h81, 1'b1));
		send_item(mk(FUNC_READ, 8'd6, 8'd3, 4'd0, 8'h00, 1'b0));
		// The unused code leaves the screen alone.
		send_item(mk(FUNC_UNUSED, 8'd10, 8'd3, 4'd0, 8'hFF, 1'b1));
		send_item(mk(FUNC_READ, 8'd202, 8'd35, 4'd0, 8'h55, 1'b1));
		send_item(mk(FUNC_DRAW, 8'd128, 8'd240, 4'd8, 8'h55, 1'b0));
		send_item(mk(FUNC_DRAW, 8'd128, 8'd240, 4'd9, 8'hAA, 1'b1));
		send_item(mk(FUNC_READ, 8'd124, 8'd0, 4'd8, 8'h00, 1'b0));
		send_item(mk(FUNC_READ, 8'd0, 8'd0, 4'd9, 8'h00, 1'b0));
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle = 9;
					rx_idle = 62;
				end
				1: begin
					tx_idle = 62;
					rx_idle = 9;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			target = n_items + 530;
			while (n_items < target) begin
				pick = $urandom_range(99);
				x = coord(SCREEN_WIDTH);
				y = coord(SCREEN_HEIGHT);
				if (pick < 55) begin
					rows = ($urandom_range(3) != 0) ? $urandom_range(1, 4) : $urandom_range(1, 16);
					// Now and then a sprite is abandoned before its last row.
					cut = ($urandom_range(9) == 0);
					for (int r = 0; r < rows; r++) begin
						send_item(mk(FUNC_DRAW, x, y, 4'(r), 8'($urandom_range(255)),
							!cut && r == rows - 1));
					end
				end else if (pick < 85) begin
					send_item(mk(FUNC_READ, x, y, 4'($urandom_range(15)),
						8'($urandom_range(255)), 1'($urandom_range(1))));
				end else if (pick < 88) begin
					send_item(mk(FUNC_CLEAR, x, y, 4'($urandom_range(15)),
						8'($urandom_range(255)), 1'($urandom_range(1))));
				end else begin
					send_item(mk(2'($urandom_range(3)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 4'($urandom_range(15)),
						8'($urandom_range(255)), 1'($urandom_range(1))));
				end
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		$display("Sent %0d draw rows, %0d reads, %0d clears and %0d unused codes",
			n_draws, n_reads, n_clears, n_ignored);
		$display("under three stall patterns; %0d sprites reported a collision.", flagged);
		if (errors == 0) begin
			$display("sprite_xor_draw_framebuffer: match");
		end else begin
			$display("sprite_xor_draw_framebuffer: mismatch");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timed out with %0d results still awaited.", awaited);
		$display("sprite_xor_draw_framebuffer: mismatch");
		$finish;
	end

endmodule
